### rtl/ccha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk chain allocator package
// Sizes, codes, memory request types and the sequencer states shared by the
// allocator modules.
// ----------------------------------------------------------------------------
package ccha_pkg;

	localparam int NODES   = 256;
	localparam int CHUNKS  = 1024;
	localparam int NODE_W  = 8;
	localparam int FNH_W   = 9;
	localparam int CHUNK_W = 10;
	localparam int LINK_W  = 11;
	localparam int BYTES_W = 22;
	localparam int CB_W    = 13;
	localparam int DVD_W   = 23;
	localparam int NCNT_W  = 9;
	localparam int CCNT_W  = 11;
	localparam int ROOM_W  = 23;

	localparam logic [LINK_W-1:0] INVALID_POINT = LINK_W'(CHUNKS);
	localparam logic [CB_W-1:0]   CB_RESET      = CB_W'(64);
	localparam logic [CB_W-1:0]   CB_MAX        = CB_W'(4096);

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_LOCATE  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_ROOM = 2'd1;
	localparam logic [1:0] ST_BEYOND  = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_NRD,
		S_DECIDE,
		S_DIV,
		S_WALK,
		S_WDATA,
		S_WEND,
		S_ADATA,
		S_FIN
	} state_t;

	typedef struct packed {
		logic               en;
		logic               we;
		logic [CHUNK_W-1:0] addr;
		logic [LINK_W-1:0]  wdata;
	} chunk_req_t;

	typedef struct packed {
		logic [LINK_W-1:0]  link;
		logic [BYTES_W-1:0] bytes;
	} node_entry_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [NODE_W-1:0] addr;
		logic              used;
		node_entry_t       wdata;
	} node_req_t;

	typedef struct packed {
		logic        used;
		node_entry_t data;
	} node_rsp_t;

endpackage

### rtl/ccha_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk chain allocator divider
// Restoring divider, one quotient bit per cycle, for byte counts by the
// chunk size.
// ----------------------------------------------------------------------------
module ccha_div import ccha_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [CB_W-1:0]  divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [CB_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [CB_W-1:0]  dvs_q;
	logic [CB_W-1:0]  rem_q;
	logic [CB_W:0]    trial;
	logic [CB_W:0]    diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CB_W-1:0] : trial[CB_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

### rtl/ccha_chunk_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk chain allocator chunk link memory
// Single-port link memory with a clearing pass after reset that chains every
// chunk to the next one.
// ----------------------------------------------------------------------------
module ccha_chunk_mem import ccha_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  chunk_req_t        req,
	output logic [LINK_W-1:0] rdata,
	output logic              clear_done
);

	logic [LINK_W-1:0] mem [CHUNKS];
	logic [LINK_W-1:0] clr_q;
	logic [LINK_W-1:0] rdata_q;

	assign clear_done = (clr_q == INVALID_POINT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clear_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clear_done) begin
			mem[clr_q[CHUNK_W-1:0]] <= clr_q + 1'b1;
		end else if (req.en && req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.en && !req.we) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/ccha_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk chain allocator node memory
// Node link and size memory with per-node written and in-use flags, so that
// a node never written reads as its reset entry.
// ----------------------------------------------------------------------------
module ccha_node_mem import ccha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  node_req_t req,
	output node_rsp_t rsp
);

	node_entry_t       mem [NODES];
	logic [NODES-1:0]  written_q;
	logic [NODES-1:0]  used_q;
	node_entry_t       raw_q;
	logic              wr_hit_q;
	logic              used_rd_q;
	logic [NODE_W-1:0] addr_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			used_q    <= '0;
		end else if (req.en && req.we) begin
			written_q[req.addr] <= 1'b1;
			used_q[req.addr]    <= req.used;
		end
	end

	always_ff @(posedge clk) begin
		if (req.en && req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.en && !req.we) begin
			raw_q     <= mem[req.addr];
			wr_hit_q  <= written_q[req.addr];
			used_rd_q <= used_q[req.addr];
			addr_rd_q <= req.addr;
		end
	end

	always_comb begin
		rsp.used = used_rd_q;
		if (wr_hit_q) begin
			rsp.data = raw_q;
		end else begin
			rsp.data.link  = LINK_W'(addr_rd_q) + LINK_W'(1);
			rsp.data.bytes = '0;
		end
	end

endmodule

### rtl/chunk_chain_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk chain allocator
// Node table and chunk pool with linked free lists; allocate, release and
// locate requests walk chunk chains held in a link memory.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the in channel (op, byte_count, node_id,
// byte_offset); each gives exactly one result beat on the out channel.
// The cfg channel sets the chunk size; writes after the first successful
// allocation are dropped until the next reset.
// One request at a time passes through the sequencer: a node memory read,
// a divide that holds it where chunks are counted, then chunk link reads
// through S_WALK and S_WDATA while walking the chain. The result beat is
// offered in the same cycle in which the next request can be accepted.
// After reset a clearing pass rebuilds the chunk free list; in_ready stays
// low until the cycle after it ends. Configuration beats are taken at once.
// A finished result waits in the output register; while the receiver stalls
// the next request can still be accepted and worked up to its result.
// ----------------------------------------------------------------------------
module chunk_chain_allocator import ccha_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CB_W-1:0]     cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [BYTES_W-1:0]  byte_count,
	input  logic [NODE_W-1:0]   node_id,
	input  logic [BYTES_W-1:0]  byte_offset,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [NODE_W-1:0]   new_node,
	output logic [CHUNK_W-1:0]  chunk_number,
	output logic [CHUNK_W-1:0]  chunk_slot,
	output logic [BYTES_W-1:0]  byte_address,
	output logic [CB_W-1:0]     bytes_in_chunk,
	output logic [NCNT_W-1:0]   free_nodes,
	output logic [CCNT_W-1:0]   free_chunks,
	output logic [ROOM_W-1:0]   free_room
);

	state_t state_q, state_d;

	logic [1:0]         op_q;
	logic [BYTES_W-1:0] size_q;
	logic [NODE_W-1:0]  id_q;
	logic [BYTES_W-1:0] off_q;
	logic [FNH_W-1:0]   fnh_q;
	logic [LINK_W-1:0]  fch_q;
	logic [NCNT_W-1:0]  fnc_q;
	logic [CCNT_W-1:0]  fcc_q;
	logic               locked_q;
	logic [CB_W-1:0]    cbreg_q;
	logic [LINK_W-1:0]  nlink_q;
	logic [BYTES_W-1:0] nbytes_q;
	logic [DVD_W-1:0]   steps_q;
	logic [LINK_W-1:0]  cur_q;
	logic [CCNT_W-1:0]  need_q;
	logic [CB_W-1:0]    within_q;

	logic [1:0]         r_status_q;
	logic [NODE_W-1:0]  r_node_q;
	logic [CHUNK_W-1:0] r_cno_q;
	logic [CHUNK_W-1:0] r_slot_q;
	logic [BYTES_W-1:0] r_addr_q;
	logic [CB_W-1:0]    r_left_q;

	logic               out_valid_q;
	logic [1:0]         o_status_q;
	logic [NODE_W-1:0]  o_node_q;
	logic [CHUNK_W-1:0] o_cno_q;
	logic [CHUNK_W-1:0] o_slot_q;
	logic [BYTES_W-1:0] o_addr_q;
	logic [CB_W-1:0]    o_left_q;
	logic [NCNT_W-1:0]  o_fnc_q;
	logic [CCNT_W-1:0]  o_fcc_q;
	logic [ROOM_W-1:0]  o_room_q;

	logic [CB_W-1:0]        cb;
	logic [CCNT_W+CB_W-1:0] room;
	logic                   alloc_refuse;
	logic                   locate_fail;
	logic                   cur_bad;
	logic                   fin_take;
	logic [CHUNK_W-1:0]     loc_slot;
	logic [DVD_W-1:0]       loc_prod;
	logic [BYTES_W-1:0]     loc_rest;
	logic [CB_W-1:0]        loc_tail;
	logic [BYTES_W-1:0]     loc_left;

	chunk_req_t        creq;
	logic [LINK_W-1:0] chunk_rdata;
	logic              clear_done;
	node_req_t         nreq;
	node_rsp_t         nrsp;

	logic             div_start;
	logic [DVD_W-1:0] div_dividend;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;
	logic [CB_W-1:0]  div_rem;

	ccha_chunk_mem u_chunk_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (creq),
		.rdata      (chunk_rdata),
		.clear_done (clear_done)
	);

	ccha_node_mem u_node_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (nreq),
		.rsp    (nrsp)
	);

	ccha_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (cb),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		if (cbreg_q == '0) begin
			cb = CB_W'(1);
		end else if (cbreg_q > CB_MAX) begin
			cb = CB_MAX;
		end else begin
			cb = cbreg_q;
		end
	end

	assign room         = fcc_q * cb;
	assign alloc_refuse = (fnc_q == '0) || (fcc_q == '0) ||
		(room <= (CCNT_W+CB_W)'(size_q)) || (fnh_q >= FNH_W'(NODES)) ||
		(fch_q >= INVALID_POINT);
	assign locate_fail  = !nrsp.used || (off_q >= nrsp.data.bytes);
	assign cur_bad      = cur_q >= INVALID_POINT;
	assign fin_take     = !out_valid_q || out_ready;

	assign loc_slot = cur_bad ? '0 : cur_q[CHUNK_W-1:0];
	assign loc_prod = loc_slot * cb;
	assign loc_rest = nbytes_q - off_q;
	assign loc_tail = cb - within_q;
	assign loc_left = (loc_rest < BYTES_W'(loc_tail)) ? loc_rest : BYTES_W'(loc_tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		creq         = '0;
		nreq         = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		unique case (state_q)
			S_CLEAR: begin
				if (clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = S_NRD;
			end
			S_NRD: begin
				nreq.en   = 1'b1;
				nreq.addr = (op_q == OP_ALLOC) ? fnh_q[NODE_W-1:0] : id_q;
				state_d   = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_FIN;
				case (op_q)
					OP_ALLOC: begin
						if (!alloc_refuse) begin
							div_start    = 1'b1;
							div_dividend = DVD_W'(size_q) + DVD_W'(cb) - DVD_W'(1);
							state_d      = S_DIV;
						end
					end
					OP_RELEASE: begin
						if (nrsp.used) begin
							div_start    = 1'b1;
							div_dividend = DVD_W'(nrsp.data.bytes) + DVD_W'(cb) - DVD_W'(1);
							state_d      = S_DIV;
						end
					end
					OP_LOCATE: begin
						if (!locate_fail) begin
							div_start    = 1'b1;
							div_dividend = DVD_W'(off_q);
							state_d      = S_DIV;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_DIV: begin
				if (div_done) state_d = S_WALK;
			end
			S_WALK: begin
				if (steps_q == '0 || cur_bad) begin
					state_d = S_WEND;
				end else begin
					creq.en   = 1'b1;
					creq.addr = cur_q[CHUNK_W-1:0];
					state_d   = S_WDATA;
				end
			end
			S_WDATA: begin
				state_d = S_WALK;
			end
			S_WEND: begin
				state_d = S_FIN;
				if (op_q == OP_ALLOC) begin
					if (!cur_bad) begin
						creq.en   = 1'b1;
						creq.addr = cur_q[CHUNK_W-1:0];
						state_d   = S_ADATA;
					end
				end else if (op_q == OP_RELEASE) begin
					if (!cur_bad) begin
						creq.en    = 1'b1;
						creq.we    = 1'b1;
						creq.addr  = cur_q[CHUNK_W-1:0];
						creq.wdata = fch_q;
					end
					nreq.en          = 1'b1;
					nreq.we          = 1'b1;
					nreq.addr        = id_q;
					nreq.used        = 1'b0;
					nreq.wdata.link  = LINK_W'(fnh_q);
					nreq.wdata.bytes = '0;
				end
			end
			S_ADATA: begin
				creq.en          = 1'b1;
				creq.we          = 1'b1;
				creq.addr        = cur_q[CHUNK_W-1:0];
				creq.wdata       = INVALID_POINT;
				nreq.en          = 1'b1;
				nreq.we          = 1'b1;
				nreq.addr        = fnh_q[NODE_W-1:0];
				nreq.used        = 1'b1;
				nreq.wdata.link  = fch_q;
				nreq.wdata.bytes = size_q;
				state_d          = S_FIN;
			end
			S_FIN: begin
				if (fin_take) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnh_q       <= '0;
			fch_q       <= '0;
			fnc_q       <= NCNT_W'(NODES);
			fcc_q       <= CCNT_W'(CHUNKS);
			locked_q    <= 1'b0;
			cbreg_q     <= CB_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && !locked_q) cbreg_q <= cfg_data;
			if (state_q == S_FIN && fin_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_WEND && op_q == OP_RELEASE) begin
				if (!cur_bad) begin
					fch_q <= nlink_q;
					fcc_q <= fcc_q + need_q;
				end
				fnh_q <= FNH_W'(id_q);
				fnc_q <= fnc_q + 1'b1;
			end
			if (state_q == S_ADATA) begin
				fnh_q    <= nlink_q[FNH_W-1:0];
				fch_q    <= chunk_rdata;
				fnc_q    <= fnc_q - 1'b1;
				fcc_q    <= fcc_q - need_q;
				locked_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q       <= op;
					size_q     <= byte_count;
					id_q       <= node_id;
					off_q      <= byte_offset;
					r_status_q <= ST_OK;
					r_node_q   <= '0;
					r_cno_q    <= '0;
					r_slot_q   <= '0;
					r_addr_q   <= '0;
					r_left_q   <= '0;
				end
			end
			S_DECIDE: begin
				nlink_q  <= nrsp.data.link;
				nbytes_q <= nrsp.data.bytes;
				if (op_q == OP_ALLOC && alloc_refuse) r_status_q <= ST_NO_ROOM;
				if (op_q == OP_LOCATE && locate_fail) r_status_q <= ST_BEYOND;
			end
			S_DIV: begin
				if (div_done) begin
					if (op_q == OP_LOCATE) begin
						steps_q  <= div_quo;
						cur_q    <= nlink_q;
						r_cno_q  <= div_quo[CHUNK_W-1:0];
						within_q <= div_rem;
					end else begin
						need_q  <= (div_quo == '0) ? CCNT_W'(1) : div_quo[CCNT_W-1:0];
						steps_q <= (div_quo == '0) ? '0 : div_quo - 1'b1;
						cur_q   <= (op_q == OP_ALLOC) ? fch_q : nlink_q;
					end
				end
			end
			S_WDATA: begin
				cur_q   <= chunk_rdata;
				steps_q <= steps_q - 1'b1;
			end
			S_WEND: begin
				if (op_q == OP_ALLOC && cur_bad) r_status_q <= ST_NO_ROOM;
				if (op_q == OP_LOCATE) begin
					r_slot_q <= loc_slot;
					r_addr_q <= loc_prod[BYTES_W-1:0] + BYTES_W'(within_q);
					r_left_q <= loc_left[CB_W-1:0];
				end
			end
			S_ADATA: begin
				r_node_q <= fnh_q[NODE_W-1:0];
			end
			S_FIN: begin
				if (fin_take) begin
					o_status_q <= r_status_q;
					o_node_q   <= r_node_q;
					o_cno_q    <= r_cno_q;
					o_slot_q   <= r_slot_q;
					o_addr_q   <= r_addr_q;
					o_left_q   <= r_left_q;
					o_fnc_q    <= fnc_q;
					o_fcc_q    <= fcc_q;
					o_room_q   <= room[ROOM_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign status         = o_status_q;
	assign new_node       = o_node_q;
	assign chunk_number   = o_cno_q;
	assign chunk_slot     = o_slot_q;
	assign byte_address   = o_addr_q;
	assign bytes_in_chunk = o_left_q;
	assign free_nodes     = o_fnc_q;
	assign free_chunks    = o_fcc_q;
	assign free_room      = o_room_q;

	a_fnc_range: assert property (@(posedge clk) disable iff (!arst_n)
		fnc_q <= NCNT_W'(NODES))
		else $error("free node count above node total");

	a_fcc_range: assert property (@(posedge clk) disable iff (!arst_n)
		fcc_q <= CCNT_W'(CHUNKS))
		else $error("free chunk count above chunk total");

	a_lock_holds: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |=> locked_q)
		else $error("chunk size lock dropped without reset");

	a_alloc_has_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADATA) |-> (fnc_q != '0 && fcc_q >= need_q))
		else $error("allocation committed without free node or chunks");

endmodule
